@@ src/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: assert that a implies b on the same edge
`define SAT_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// label: assert that a implies b on the next edge
`define SAT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

@@ src/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and codes for the segment adjacency test
// ----------------------------------------------------------------------------
package sat_pkg;

   typedef enum logic [1:0] {
      VERDICT_ADJACENT = 2'd0,
      VERDICT_PARALLEL = 2'd1,
      VERDICT_NO_MEET  = 2'd2,
      VERDICT_TOO_FAR  = 2'd3
   } verdict_type;

   typedef enum logic [0:0] {
      CSR_COS_SQ   = 1'b0,
      CSR_RATIO_SQ = 1'b1
   } csr_index_type;

   localparam logic [15:0] COS_SQ_RESET   = 16'd63559;
   localparam logic [15:0] RATIO_SQ_RESET = 16'd4956;

   // coordinate fraction bits; they cancel in every ratio the block tests
   localparam int FRAC_BITS = 4;

endpackage

@@ src/segment_adjacency_test.sv @@
// ----------------------------------------------------------------------------
// segment_adjacency_test
// corner-junction test for a pair of image line segments
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while the pipe advances and returns one
// result word per pair through a five-stage pipeline: differences, products,
// squares, scaled compares, verdict. The whole pipe advances whenever the
// output register is empty or being taken, so a stalled consumer holds it and
// nothing is lost or repeated. Coordinates are unsigned fixed point; the
// fraction bits cancel in every ratio. Write the limit registers only while
// the pipe is empty.
module segment_adjacency_test #(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [((8*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // adjacent, verdict, zero fill
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_we,
   input  logic [0:0]              csr_index,
   input  logic [15:0]             csr_wdata
);
   import sat_pkg::*;

   logic [15:0] cos_sq_ff, ratio_sq_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_sq_ff   <= COS_SQ_RESET;
         ratio_sq_ff <= RATIO_SQ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COS_SQ:   cos_sq_ff   <= csr_wdata;
            CSR_RATIO_SQ: ratio_sq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipe moves when the output slot is free or leaving
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   verdict_type verdict;
   sat_core #(.CW(COORD_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid && req_tready),
      .in_coords   (req_tdata[8*COORD_BITS-1:0]),
      .cos_sq      (cos_sq_ff),
      .ratio_sq    (ratio_sq_ff),
      .out_valid   (rsp_tvalid),
      .out_verdict (verdict)
   );

   assign rsp_tdata = {5'd0, verdict, (verdict == VERDICT_ADJACENT)};

endmodule

@@ src/sat_core.sv @@
// ----------------------------------------------------------------------------
// sat_core
// pipelined datapath: differences, products, squares, wide compares, verdict
// ----------------------------------------------------------------------------
module sat_core #(
   parameter int CW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [8*CW-1:0]      in_coords,
   input  logic [15:0]          cos_sq,
   input  logic [15:0]          ratio_sq,
   output logic                 out_valid,
   output sat_pkg::verdict_type out_verdict
);
   import sat_pkg::*;

   localparam int DW = CW + 1;        // signed difference
   localparam int PW = 2 * DW;        // one product
   localparam int SW = PW + 1;        // sum of two products
   localparam int LW = 2 * SW;        // square of a sum
   localparam int WW = 2 * LW + 16;   // scaled product of squares

   // valid pipe
   logic [4:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end
   assign out_valid = vld_ff[4];

   // stage 1: differences
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff, ex_ff, ey_ff;
   function automatic logic signed [DW-1:0] sub(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
      sub = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         dax_ff <= sub(in_coords[2*CW +: CW], in_coords[0*CW +: CW]);
         day_ff <= sub(in_coords[3*CW +: CW], in_coords[1*CW +: CW]);
         dbx_ff <= sub(in_coords[6*CW +: CW], in_coords[4*CW +: CW]);
         dby_ff <= sub(in_coords[7*CW +: CW], in_coords[5*CW +: CW]);
         ex_ff  <= sub(in_coords[4*CW +: CW], in_coords[0*CW +: CW]);
         ey_ff  <= sub(in_coords[5*CW +: CW], in_coords[1*CW +: CW]);
      end
   end

   // stage 2: sums of products
   function automatic logic signed [SW-1:0] mul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
      mul = SW'(a) * SW'(b);
   endfunction
   logic [SW-1:0] lena_ff, lenb_ff;
   logic signed [SW-1:0] dot_ff, w_ff, nt_ff, ns_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         lena_ff <= $unsigned(mul(dax_ff, dax_ff) + mul(day_ff, day_ff));
         lenb_ff <= $unsigned(mul(dbx_ff, dbx_ff) + mul(dby_ff, dby_ff));
         dot_ff  <= mul(dax_ff, dbx_ff) + mul(day_ff, dby_ff);
         w_ff    <= mul(dax_ff, dby_ff) - mul(day_ff, dbx_ff);
         nt_ff   <= mul(ex_ff, dby_ff) - mul(ey_ff, dbx_ff);
         ns_ff   <= mul(ex_ff, day_ff) - mul(ey_ff, dax_ff);
      end
   end

   // stage 3: squares and the length product
   logic [SW-1:0] m0, m1, m2, m3, m4, mw;
   function automatic logic [SW-1:0] mg(input logic signed [SW:0] v);
      mg = v[SW] ? SW'(-v) : SW'(v);
   endfunction
   assign m0 = mg({dot_ff[SW-1], dot_ff});
   assign m1 = mg({nt_ff[SW-1], nt_ff});
   assign m2 = mg({nt_ff[SW-1], nt_ff} - {w_ff[SW-1], w_ff});
   assign m3 = mg({ns_ff[SW-1], ns_ff});
   assign m4 = mg({ns_ff[SW-1], ns_ff} - {w_ff[SW-1], w_ff});
   assign mw = mg({w_ff[SW-1], w_ff});
   logic [LW-1:0] dsq_ff, lp_ff, wsq_ff, n1_ff, n2_ff, n3_ff, n4_ff;
   logic          zero3_ff, wz3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dsq_ff   <= LW'(m0) * LW'(m0);
         lp_ff    <= LW'(lena_ff) * LW'(lenb_ff);
         wsq_ff   <= LW'(mw) * LW'(mw);
         n1_ff    <= LW'(m1) * LW'(m1);
         n2_ff    <= LW'(m2) * LW'(m2);
         n3_ff    <= LW'(m3) * LW'(m3);
         n4_ff    <= LW'(m4) * LW'(m4);
         zero3_ff <= (lena_ff == '0) || (lenb_ff == '0);
         wz3_ff   <= (w_ff == '0);
      end
   end

   // stage 4: scaled compares
   logic par4_ff, ok4_ff, zero4_ff, wz4_ff;
   logic [WW-1:0] rhs;
   assign rhs = WW'(wsq_ff) * WW'(ratio_sq);
   always_ff @(posedge clock) begin
      if (adv) begin
         par4_ff  <= (WW'(dsq_ff) << 16) > WW'(lp_ff) * WW'(cos_sq);
         ok4_ff   <= ((WW'(n1_ff) << 12) <= rhs) && ((WW'(n2_ff) << 12) <= rhs) &&
                     ((WW'(n3_ff) << 12) <= rhs) && ((WW'(n4_ff) << 12) <= rhs);
         zero4_ff <= zero3_ff;
         wz4_ff   <= wz3_ff;
      end
   end

   // stage 5: verdict
   verdict_type verdict_ff, verdict_in;
   always_comb begin
      if (zero4_ff)      verdict_in = VERDICT_NO_MEET;
      else if (par4_ff)  verdict_in = VERDICT_PARALLEL;
      else if (wz4_ff)   verdict_in = VERDICT_NO_MEET;
      else if (ok4_ff)   verdict_in = VERDICT_ADJACENT;
      else               verdict_in = VERDICT_TOO_FAR;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         verdict_ff <= verdict_in;
      end
   end
   assign out_verdict = verdict_ff;

endmodule

@@ src/sat_checker.sv @@
// ----------------------------------------------------------------------------
// sat_checker
// port-level checks for the segment adjacency test
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sat_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready
);
   import sat_pkg::*;

   logic adj_ok, rsp_stall;
   assign adj_ok    = rsp_tdata[0] == (rsp_tdata[2:1] == VERDICT_ADJACENT);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `SAT_ASSERT_IMP(adj_matches_verdict, clock, reset, rsp_tvalid, adj_ok)
   `SAT_ASSERT_IMP(fill_zero, clock, reset, rsp_tvalid, rsp_tdata[7:3] == 5'd0)
   `SAT_ASSERT_IMP(ready_when_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   `SAT_ASSERT_NEXT(stall_holds, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind segment_adjacency_test sat_checker u_sat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

@@ dv/segment_adjacency_test_test.sv @@
// ----------------------------------------------------------------------------
// segment_adjacency_test_test
// self-checking bench for the segment corner-junction test
// ----------------------------------------------------------------------------
// A directed table walks the zero-length, parallel, threshold and extreme
// coordinate cases, and then random segment pairs follow under several limit
// settings. Every pair is predicted with exact wide integer math and every
// result word is checked in order against the oldest prediction. Both stream
// sides idle at random, the result side holds off once for a long stretch,
// and the sender drains the pipe before each limit change.
module segment_adjacency_test_test;
   import sat_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic [127:0]  req_tdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          csr_we = 1'b0;
   logic [0:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   typedef struct packed {
      logic [15:0] by1, bx1, by0, bx0, ay1, ax1, ay0, ax0;
   } pair_type;

   typedef struct {
      logic        adjacent;
      verdict_type verdict;
   } outcome_type;

   // directed row: pair, and a typed-in verdict where it is obvious
   typedef struct {
      pair_type    pair;
      logic        known;
      verdict_type verdict;
   } row_type;

   segment_adjacency_test dut (.*);

   always #5 clock = ~clock;

   // local copy of the limit registers
   logic [15:0] cos_sq_lim   = COS_SQ_RESET;
   logic [15:0] ratio_sq_lim = RATIO_SQ_RESET;

   outcome_type pending_verdicts[$];
   int       mismatches = 0;
   int       words_out = 0;
   int       words_in = 0;
   int       adj_seen = 0;
   bit       hold_off = 0;

   // exact predictor: all tests on squared quantities, 160-bit headroom
   function automatic verdict_type judge_pair(pair_type p);
      logic signed [40:0]  dax, day, dbx, dby, ex, ey;
      logic signed [80:0]  dot, w, nt, ns;
      logic [159:0]        lena, lenb, dot_sq, len_prod, rhs;
      logic signed [80:0]  terms[4];
      logic [159:0]        nmag;
      bit                  ok;
      dax = $signed({25'd0, p.ax1}) - $signed({25'd0, p.ax0});
      day = $signed({25'd0, p.ay1}) - $signed({25'd0, p.ay0});
      dbx = $signed({25'd0, p.bx1}) - $signed({25'd0, p.bx0});
      dby = $signed({25'd0, p.by1}) - $signed({25'd0, p.by0});
      ex  = $signed({25'd0, p.bx0}) - $signed({25'd0, p.ax0});
      ey  = $signed({25'd0, p.by0}) - $signed({25'd0, p.ay0});
      lena = 160'(dax * dax + day * day);
      lenb = 160'(dbx * dbx + dby * dby);
      if (lena == 0 || lenb == 0) return VERDICT_NO_MEET;
      dot = dax * dbx + day * dby;
      if (dot < 0) dot = -dot;
      dot_sq   = (160'(dot) * 160'(dot)) << 16;
      len_prod = lena * lenb * 160'(cos_sq_lim);
      if (dot_sq > len_prod) return VERDICT_PARALLEL;
      w = dax * dby - day * dbx;
      if (w == 0) return VERDICT_NO_MEET;
      nt = ex * dby - ey * dbx;
      ns = ex * day - ey * dax;
      terms = '{nt, nt - w, ns, ns - w};
      if (w < 0) w = -w;
      rhs = 160'(w) * 160'(w) * 160'(ratio_sq_lim);
      ok = 1;
      foreach (terms[i]) begin
         nmag = 160'(terms[i] < 0 ? -terms[i] : terms[i]);
         if (((nmag * nmag) << 12) > rhs) ok = 0;
      end
      return ok ? VERDICT_ADJACENT : VERDICT_TOO_FAR;
   endfunction

   function automatic outcome_type outcome_of(verdict_type v);
      outcome_type o;
      o.verdict  = v;
      o.adjacent = (v == VERDICT_ADJACENT);
      return o;
   endfunction

   function automatic pair_type make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
      pair_type p;
      p = '{16'(by1), 16'(bx1), 16'(by0), 16'(bx0), 16'(ay1), 16'(ax1), 16'(ay0), 16'(ax0)};
      return p;
   endfunction

   // corner-like pair: segments meet near a shared point, random content
   function automatic pair_type corner_pair();
      int cx, cy, span;
      span = ($urandom_range(0, 3) == 0) ? 30000 : 600;
      cx = $urandom_range(span, 65535 - span);
      cy = $urandom_range(span, 65535 - span);
      return make_pair(cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40) - 20,
                       cx + $urandom_range(0, 2 * span) - span,
                       cy + $urandom_range(0, 2 * span) - span,
                       cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40) - 20,
                       cx + $urandom_range(0, 2 * span) - span,
                       cy + $urandom_range(0, 2 * span) - span);
   endfunction

   function automatic pair_type random_pair();
      case ($urandom_range(0, 9))
         0, 1:    return pair_type'({$urandom, $urandom, $urandom, $urandom});
         2: begin // nearly parallel, shifted copy
            pair_type p;
            p = pair_type'({$urandom, $urandom, $urandom, $urandom});
            p.bx1 = p.bx0 + (p.ax1 - p.ax0) + 16'($urandom_range(0, 6));
            p.by1 = p.by0 + (p.ay1 - p.ay0);
            return p;
         end
         3: begin // degenerate segment
            pair_type p;
            p = pair_type'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 1)) {p.ax1, p.ay1} = {p.ax0, p.ay0};
            else {p.bx1, p.by1} = {p.bx0, p.by0};
            return p;
         end
         default: return corner_pair();
      endcase
   endfunction

   // send one pair after a random gap; hold valid until accepted
   task automatic send_pair(pair_type p, bit quick);
      int gap;
      gap = quick ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_verdicts.insert(pending_verdicts.size(), outcome_of(judge_pair(p)));
      req_tdata  <= 128'(p);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_in++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(logic [15:0] cos_sq, logic [15:0] ratio_sq);
      csr_we <= 1'b1;
      csr_index <= CSR_COS_SQ;
      csr_wdata <= cos_sq;
      @(posedge clock);
      csr_index <= CSR_RATIO_SQ;
      csr_wdata <= ratio_sq;
      @(posedge clock);
      csr_we <= 1'b0;
      cos_sq_lim   = cos_sq;
      ratio_sq_lim = ratio_sq;
   endtask

   // result side: random stalls, long hold-off on request
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // checker: compare each taken word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            outcome_type exp_o;
            exp_o = pending_verdicts.pop_front();
            words_out++;
            if (exp_o.adjacent) adj_seen++;
            if (rsp_tdata[0] !== exp_o.adjacent || rsp_tdata[2:1] !== exp_o.verdict
                || rsp_tdata[7:3] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected adjacent %b verdict %0d, got data %b",
                           words_out, exp_o.adjacent, exp_o.verdict, rsp_tdata);
            end
         end
      end
   end

   // stimulus
   initial begin
      row_type rows[$];
      verdict_type v;
      logic [15:0] cos_set[4];
      logic [15:0] ratio_set[4];
      cos_set   = '{16'd0, 16'd65535, 16'd40000, COS_SQ_RESET};
      ratio_set = '{16'd4096, 16'd65535, 16'd9000, RATIO_SQ_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset limits
      rows.insert(rows.size(), '{make_pair(5, 5, 5, 5, 0, 0, 100, 40), 1, VERDICT_NO_MEET});
      rows.insert(rows.size(), '{make_pair(0, 0, 100, 40, 7, 7, 7, 7), 1, VERDICT_NO_MEET});
      rows.insert(rows.size(), '{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, VERDICT_NO_MEET});
      rows.insert(rows.size(), '{make_pair(0, 0, 100, 0, 0, 50, 300, 50), 1,
                                 VERDICT_PARALLEL});
      rows.insert(rows.size(), '{make_pair(0, 0, 65535, 65535, 65535, 65535, 0, 0), 1,
                                 VERDICT_PARALLEL});
      rows.insert(rows.size(), '{make_pair(0, 0, 100, 0, 0, 0, 0, 100), 1,
                                 VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(0, 0, 65535, 0, 65535, 0, 65535, 65535), 1,
                                 VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(0, 0, 10, 0, 5000, 0, 5000, 10), 1,
                                 VERDICT_TOO_FAR});
      // crossing diagonals meet at both midpoints
      rows.insert(rows.size(), '{make_pair(0, 65535, 65535, 0, 0, 0, 65535, 65535), 1,
                                 VERDICT_ADJACENT});
      // far end at 1.1 lengths sits just past the rounded default limit
      rows.insert(rows.size(), '{make_pair(0, 0, 100, 0, 110, 0, 110, 100), 0,
                                 VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(0, 0, 100, 0, 111, 0, 111, 100), 0,
                                 VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(65535, 65535, 0, 65535, 65535, 65535, 65535, 0),
                                 0, VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(0, 0, 1000, 176, 0, 0, 1000, 0), 0,
                                 VERDICT_ADJACENT});
      rows.insert(rows.size(), '{make_pair(0, 0, 1000, 177, 0, 0, 1000, 0), 0,
                                 VERDICT_ADJACENT});
      foreach (rows[i]) begin
         if (rows[i].known) begin
            v = judge_pair(rows[i].pair);
            if (v != rows[i].verdict) begin
               mismatches++;
               $display("directed row %0d: predictor gives %0d, table %0d", i, v,
                        rows[i].verdict);
            end
         end
         send_pair(rows[i].pair, 0);
      end
      drain();

      // equality on both limits: 45 degrees against 0.5, and a far end
      // exactly one length away against a ratio of 1
      write_limits(16'd32768, 16'd4096);
      send_pair(make_pair(0, 0, 100, 0, 0, 0, 100, 100), 0);
      send_pair(make_pair(0, 0, 100, 0, 0, 0, 101, 100), 0);
      drain();

      // random phases over several limit settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) write_limits(cos_set[ph], ratio_set[(ph + 1) % 4]);
         else write_limits(16'($urandom), 16'($urandom_range(4096, 65535)));
         if (ph == 2) hold_off = 1;
         for (int n = 0; n < 100; n++) send_pair(random_pair(), ph == 2);
         drain();
      end

      $display("%0d pairs sent, %0d results checked, %0d adjacent, six limit settings",
               words_in, words_out, adj_seen);
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
